[src/llsx_pkg.sv]
// llsx_pkg: shared widths, constants, stage types and the degree arctangent table
// for the lon/lat to sphere xyz converter; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package llsx_pkg;

    // rotation stages of the trig unit and size of the arctangent table
    localparam int TRIG_STAGES = 16;
    localparam int ATAN_LEN    = 24;
    localparam int CORDIC_LEN  = (TRIG_STAGES < ATAN_LEN) ? TRIG_STAGES : ATAN_LEN;

    // field widths
    localparam int LON_W   = 25;
    localparam int LAT_W   = 24;
    localparam int OFF_W   = 32;
    localparam int BASE_W  = 32;
    localparam int COORD_W = 34;

    // internal widths
    localparam int WRAP_W = 34;  // Q.24 degrees before wrapping
    localparam int ANG_W  = 32;  // Q.24 degrees after folding
    localparam int CXY_W  = 33;  // trig vector, Q2.30 with headroom
    localparam int TRIG_W = 18;  // rounded sine and cosine, Q16
    localparam int RAD_W  = 34;  // base radius plus offset
    localparam int PROD_W = RAD_W + TRIG_W;

    // angle constants in Q.24 degrees
    localparam logic signed [WRAP_W-1:0] HALF_TURN    = 34'sd3019898880;
    localparam logic signed [WRAP_W-1:0] FULL_TURN    = 34'sd6039797760;
    localparam logic signed [WRAP_W-1:0] QUARTER_TURN = 34'sd1509949440;

    // start vector, the inverse rotation gain in Q2.30
    localparam logic signed [CXY_W-1:0] CORDIC_START = 33'sd652032874;

    // register indexes on the config port (paddr[2])
    localparam logic REG_BASE_RADIUS = 1'b0;
    localparam logic [BASE_W-1:0] BASE_RADIUS_RESET = 32'd65536;

    // item after angle reduction
    typedef struct packed {
        logic signed [ANG_W-1:0] lon_ang;
        logic                    lon_neg;
        logic signed [ANG_W-1:0] lat_ang;
        logic                    lat_neg;
        logic signed [RAD_W-1:0] radius;
    } prep_t;

    // one rotation lane
    typedef struct packed {
        logic signed [ANG_W-1:0] ang;
        logic signed [CXY_W-1:0] x;
        logic signed [CXY_W-1:0] y;
        logic                    neg;
    } lane_t;

    // item inside and after the trig pipeline
    typedef struct packed {
        lane_t                   lon;
        lane_t                   lat;
        logic signed [RAD_W-1:0] radius;
    } cordic_t;

    // atan(2^-i) in Q.24 degrees
    function automatic logic signed [ANG_W-1:0] atan_deg(input int idx);
        logic signed [ANG_W-1:0] v;
        case (idx)
            0:       v = 32'sd754974720;
            1:       v = 32'sd445687602;
            2:       v = 32'sd235489088;
            3:       v = 32'sd119537938;
            4:       v = 32'sd60000934;
            5:       v = 32'sd30029717;
            6:       v = 32'sd15018523;
            7:       v = 32'sd7509720;
            8:       v = 32'sd3754917;
            9:       v = 32'sd1877466;
            10:      v = 32'sd938734;
            11:      v = 32'sd469367;
            12:      v = 32'sd234684;
            13:      v = 32'sd117342;
            14:      v = 32'sd58671;
            15:      v = 32'sd29335;
            16:      v = 32'sd14668;
            17:      v = 32'sd7334;
            18:      v = 32'sd3667;
            19:      v = 32'sd1833;
            20:      v = 32'sd917;
            21:      v = 32'sd458;
            22:      v = 32'sd229;
            23:      v = 32'sd115;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

[src/llsx_prep.sv]
// llsx_prep: input register with radius add, angle wrap to +-180 and fold to +-90
// three pipeline stages; depends on llsx_pkg
`timescale 1ns / 1ps
`default_nettype none

module llsx_prep (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic signed [llsx_pkg::LON_W-1:0]   lon,
    input  wire logic signed [llsx_pkg::LAT_W-1:0]   lat,
    input  wire logic signed [llsx_pkg::OFF_W-1:0]   off,
    input  wire logic        [llsx_pkg::BASE_W-1:0]  base_radius,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output llsx_pkg::prep_t                          out_item
);

    typedef struct packed {
        logic signed [llsx_pkg::ANG_W-1:0] ang;
        logic                              neg;
    } fold_t;

    // bring a Q.24 degree angle into [-180, 180]
    function automatic logic signed [llsx_pkg::WRAP_W-1:0] wrap_ang(
        input logic signed [llsx_pkg::WRAP_W-1:0] a
    );
        logic signed [llsx_pkg::WRAP_W-1:0] r;
        r = a;
        if (a > llsx_pkg::HALF_TURN) begin
            r = a - llsx_pkg::FULL_TURN;
        end else if (a < -llsx_pkg::HALF_TURN) begin
            r = a + llsx_pkg::FULL_TURN;
        end
        return r;
    endfunction

    // fold into [-90, 90] by a half turn, flagging a sign flip of sin and cos
    function automatic fold_t fold_ang(input logic signed [llsx_pkg::WRAP_W-1:0] a);
        fold_t f;
        logic signed [llsx_pkg::WRAP_W-1:0] r;
        r = a;
        f.neg = 1'b0;
        if (a > llsx_pkg::QUARTER_TURN) begin
            r = a - llsx_pkg::HALF_TURN;
            f.neg = 1'b1;
        end else if (a < -llsx_pkg::QUARTER_TURN) begin
            r = a + llsx_pkg::HALF_TURN;
            f.neg = 1'b1;
        end
        f.ang = r[llsx_pkg::ANG_W-1:0];
        return f;
    endfunction

    logic                                v1_reg, v2_reg, v3_reg;
    logic                                rdy1, rdy2, rdy3;
    logic signed [llsx_pkg::LON_W-1:0]   lon1_reg;
    logic signed [llsx_pkg::LAT_W-1:0]   lat1_reg;
    logic signed [llsx_pkg::RAD_W-1:0]   rad1_reg, rad2_reg;
    logic signed [llsx_pkg::RAD_W-1:0]   rad_next;
    logic signed [llsx_pkg::WRAP_W-1:0]  lonw_reg, latw_reg;
    logic signed [llsx_pkg::WRAP_W-1:0]  lonw_next, latw_next;
    fold_t                               lon_fold, lat_fold;
    llsx_pkg::prep_t                     item_reg;

    // ready chain, a stage takes data when empty or when it drains
    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    // radius = base + offset
    assign rad_next = $signed({2'b00, base_radius}) + llsx_pkg::RAD_W'(off);

    // widen to Q.24 and wrap
    assign lonw_next = wrap_ang(llsx_pkg::WRAP_W'($signed({lon1_reg, 8'd0})));
    assign latw_next = wrap_ang(llsx_pkg::WRAP_W'($signed({lat1_reg, 8'd0})));

    // fold
    assign lon_fold = fold_ang(lonw_reg);
    assign lat_fold = fold_ang(latw_reg);

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
        end
    end

    // payload stages
    always_ff @(posedge aclk) begin
        if (rdy1) begin
            lon1_reg <= lon;
            lat1_reg <= lat;
            rad1_reg <= rad_next;
        end
        if (rdy2) begin
            lonw_reg <= lonw_next;
            latw_reg <= latw_next;
            rad2_reg <= rad1_reg;
        end
        if (rdy3) begin
            item_reg.lon_ang <= lon_fold.ang;
            item_reg.lon_neg <= lon_fold.neg;
            item_reg.lat_ang <= lat_fold.ang;
            item_reg.lat_neg <= lat_fold.neg;
            item_reg.radius  <= rad2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign out_item  = item_reg;

endmodule

`default_nettype wire

[src/llsx_cordic.sv]
// llsx_cordic: pipelined rotation-mode trig unit on degree angles, one stage per
// rotation, longitude and latitude lanes side by side; depends on llsx_pkg
`timescale 1ns / 1ps
`default_nettype none

module llsx_cordic (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire llsx_pkg::prep_t in_item,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output llsx_pkg::cordic_t    out_item
);

    localparam int N = llsx_pkg::CORDIC_LEN;

    // one micro-rotation by atan(2^-shift)
    function automatic llsx_pkg::lane_t rotate(
        input llsx_pkg::lane_t                   l,
        input int                                shift,
        input logic signed [llsx_pkg::ANG_W-1:0] step
    );
        llsx_pkg::lane_t r;
        logic signed [llsx_pkg::CXY_W-1:0] xs, ys;
        xs = $signed(l.x) >>> shift;
        ys = $signed(l.y) >>> shift;
        r.neg = l.neg;
        if ($signed(l.ang) >= 0) begin
            r.x   = $signed(l.x) - ys;
            r.y   = $signed(l.y) + xs;
            r.ang = $signed(l.ang) - step;
        end else begin
            r.x   = $signed(l.x) + ys;
            r.y   = $signed(l.y) - xs;
            r.ang = $signed(l.ang) + step;
        end
        return r;
    endfunction

    llsx_pkg::cordic_t stage_reg [N];
    llsx_pkg::cordic_t stage_in  [N];
    llsx_pkg::cordic_t stage_next[N];
    logic [N-1:0]      valid_reg;
    logic [N-1:0]      valid_in;
    logic [N:0]        rdy;

    // first stage starts from the gain-corrected unit vector
    always_comb begin
        stage_in[0].lon.ang = in_item.lon_ang;
        stage_in[0].lon.x   = llsx_pkg::CORDIC_START;
        stage_in[0].lon.y   = '0;
        stage_in[0].lon.neg = in_item.lon_neg;
        stage_in[0].lat.ang = in_item.lat_ang;
        stage_in[0].lat.x   = llsx_pkg::CORDIC_START;
        stage_in[0].lat.y   = '0;
        stage_in[0].lat.neg = in_item.lat_neg;
        stage_in[0].radius  = in_item.radius;
    end
    assign valid_in[0] = in_valid;
    assign rdy[N]      = out_ready;

    for (genvar i = 0; i < N; i++) begin : g_stage
        if (i > 0) begin : g_link
            assign stage_in[i] = stage_reg[i-1];
            assign valid_in[i] = valid_reg[i-1];
        end

        // rotation step i for both lanes
        always_comb begin
            stage_next[i].lon    = rotate(stage_in[i].lon, i, llsx_pkg::atan_deg(i));
            stage_next[i].lat    = rotate(stage_in[i].lat, i, llsx_pkg::atan_deg(i));
            stage_next[i].radius = stage_in[i].radius;
        end

        assign rdy[i] = !valid_reg[i] || rdy[i+1];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[i] <= 1'b0;
            end else if (rdy[i]) begin
                valid_reg[i] <= valid_in[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (rdy[i]) begin
                stage_reg[i] <= stage_next[i];
            end
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = valid_reg[N-1];
    assign out_item  = stage_reg[N-1];

endmodule

`default_nettype wire

[src/llsx_scale.sv]
// llsx_scale: rounds sine and cosine, scales by the radius in two multiply levels
// and negates (z in stage c, x, y at output); five stages; depends on llsx_pkg
`timescale 1ns / 1ps
`default_nettype none

module llsx_scale (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire llsx_pkg::cordic_t                    in_item,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic signed [llsx_pkg::COORD_W-1:0]       x_coord,
    output logic signed [llsx_pkg::COORD_W-1:0]       y_coord,
    output logic signed [llsx_pkg::COORD_W-1:0]       z_coord
);

    localparam int TW = llsx_pkg::TRIG_W;
    localparam int RW = llsx_pkg::RAD_W;
    localparam int PW = llsx_pkg::PROD_W;
    localparam int CW = llsx_pkg::COORD_W;
    localparam logic signed [RW-1:0] TRIG_ONE = 34'sd65536;

    // Q2.30 to Q16 with round half up, clamp to +-1.0, apply the fold flip
    function automatic logic signed [TW-1:0] trig_round(
        input logic signed [llsx_pkg::CXY_W-1:0] v,
        input logic                              neg
    );
        logic signed [RW-1:0] sum, sh;
        logic signed [TW-1:0] t;
        sum = RW'(v) + 34'sd8192;
        sh  = sum >>> 14;
        if (sh > TRIG_ONE) begin
            sh = TRIG_ONE;
        end else if (sh < -TRIG_ONE) begin
            sh = -TRIG_ONE;
        end
        t = sh[TW-1:0];
        if (neg) begin
            t = -t;
        end
        return t;
    endfunction

    logic                 va_reg, vb_reg, vc_reg, vd_reg, ve_reg;
    logic                 rdy_a, rdy_b, rdy_c, rdy_d, rdy_e;
    logic signed [TW-1:0] slon_a_reg, clon_a_reg, slat_a_reg, clat_a_reg;
    logic signed [RW-1:0] rad_a_reg;
    logic signed [PW-1:0] prc_b_reg, pz_b_reg;
    logic signed [TW-1:0] slon_b_reg, clon_b_reg, slon_c_reg, clon_c_reg;
    logic signed [PW-1:0] prc_round;
    logic signed [PW:0]   pz_neg;
    logic signed [RW-1:0] rc_c_reg;
    logic signed [CW-1:0] z_c_reg, z_d_reg;
    logic signed [PW-1:0] px_d_reg, py_d_reg;
    logic signed [PW:0]   px_neg, py_neg;
    logic signed [CW-1:0] x_e_reg, y_e_reg, z_e_reg;
    logic signed [CW-1:0] x_next, y_next, z_next;

    // ready chain
    assign rdy_e    = !ve_reg || out_ready;
    assign rdy_d    = !vd_reg || rdy_e;
    assign rdy_c    = !vc_reg || rdy_d;
    assign rdy_b    = !vb_reg || rdy_c;
    assign rdy_a    = !va_reg || rdy_b;
    assign in_ready = rdy_a;

    // round R*cos(lat); -round(p) is floor((32767 - p) / 2^16)
    assign prc_round = prc_b_reg + 52'sd32768;
    assign pz_neg    = 53'sd32767 - (PW+1)'(pz_b_reg);
    assign px_neg    = 53'sd32767 - (PW+1)'(px_d_reg);
    assign py_neg    = 53'sd32767 - (PW+1)'(py_d_reg);
    assign x_next    = CW'(px_neg >>> 16);
    assign y_next    = CW'(py_neg >>> 16);
    assign z_next    = CW'(pz_neg >>> 16);

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
            ve_reg <= 1'b0;
        end else begin
            if (rdy_a) va_reg <= in_valid;
            if (rdy_b) vb_reg <= va_reg;
            if (rdy_c) vc_reg <= vb_reg;
            if (rdy_d) vd_reg <= vc_reg;
            if (rdy_e) ve_reg <= vd_reg;
        end
    end

    // payload stages
    always_ff @(posedge aclk) begin
        // trig rounding
        if (rdy_a) begin
            slon_a_reg <= trig_round(in_item.lon.y, in_item.lon.neg);
            clon_a_reg <= trig_round(in_item.lon.x, in_item.lon.neg);
            slat_a_reg <= trig_round(in_item.lat.y, in_item.lat.neg);
            clat_a_reg <= trig_round(in_item.lat.x, in_item.lat.neg);
            rad_a_reg  <= in_item.radius;
        end
        // radius products
        if (rdy_b) begin
            prc_b_reg  <= rad_a_reg * clat_a_reg;
            pz_b_reg   <= rad_a_reg * slat_a_reg;
            slon_b_reg <= slon_a_reg;
            clon_b_reg <= clon_a_reg;
        end
        // round R*cos(lat), finish z
        if (rdy_c) begin
            rc_c_reg   <= RW'(prc_round >>> 16);
            z_c_reg    <= z_next;
            slon_c_reg <= slon_b_reg;
            clon_c_reg <= clon_b_reg;
        end
        // longitude products
        if (rdy_d) begin
            px_d_reg <= rc_c_reg * slon_c_reg;
            py_d_reg <= rc_c_reg * clon_c_reg;
            z_d_reg  <= z_c_reg;
        end
        // output register
        if (rdy_e) begin
            x_e_reg <= x_next;
            y_e_reg <= y_next;
            z_e_reg <= z_d_reg;
        end
    end

    assign out_valid = ve_reg;
    assign x_coord   = x_e_reg;
    assign y_coord   = y_e_reg;
    assign z_coord   = z_e_reg;

endmodule

`default_nettype wire

[src/lonlat_to_sphere_xyz_core.sv]
// lonlat_to_sphere_xyz_core: top level, config register and stream pipeline
// depends on llsx_pkg, llsx_prep, llsx_cordic, llsx_scale
//
// Converts one point per transfer from longitude/latitude in degrees plus a
// height offset into x, y, z on a sphere of radius base_radius + offset.
// Input stream s_*: tdata holds longitude, latitude, height_offset.
// Output stream m_*: tdata holds x_coord, y_coord, z_coord, one result per input.
// Config: APB-style port, base_radius at byte address 0 (Q16.16, reset 1.0);
// write it only while no transfer is in flight. pready is tied high.
// The path from input transfer to m_tvalid runs through llsx_prep, the
// TRIG_STAGES rotation stages (16) and llsx_scale. Throughput is one point
// per cycle while m_tready stays high, set by one pipelined rotation stage per
// arctangent step and one multiply level per register stage.
// Every stage holds a valid bit and moves when it is empty or its successor
// moves, so a stalled receiver freezes only the occupied stages behind it;
// bubbles still fill and s_tready drops only once the whole pipe is full.
// Reset (aresetn low, synchronous) empties the pipe and restores base_radius.
`timescale 1ns / 1ps
`default_nettype none

module lonlat_to_sphere_xyz_core (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // input stream
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [87:0]  s_tdata,   // longitude[24:0], latitude[48:25], height_offset[80:49]
    // output stream
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [103:0]      m_tdata,   // x_coord[33:0], y_coord[67:34], z_coord[101:68]
    // config port
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [llsx_pkg::BASE_W-1:0]          base_radius_reg;
    logic                                 cfg_write;
    logic                                 prep_valid, prep_ready;
    llsx_pkg::prep_t                      prep_item;
    logic                                 cor_valid, cor_ready;
    llsx_pkg::cordic_t                    cor_item;
    logic signed [llsx_pkg::COORD_W-1:0]  x_coord, y_coord, z_coord;

    // config register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_radius_reg <= llsx_pkg::BASE_RADIUS_RESET;
        end else if (cfg_write && paddr[2] == llsx_pkg::REG_BASE_RADIUS) begin
            base_radius_reg <= pwdata;
        end
    end

    assign prdata = (paddr[2] == llsx_pkg::REG_BASE_RADIUS) ? base_radius_reg : 32'd0;

    // angle reduction and radius
    llsx_prep u_prep (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .lon         ($signed(s_tdata[24:0])),
        .lat         ($signed(s_tdata[48:25])),
        .off         ($signed(s_tdata[80:49])),
        .base_radius (base_radius_reg),
        .out_valid   (prep_valid),
        .out_ready   (prep_ready),
        .out_item    (prep_item)
    );

    // trig pipeline
    llsx_cordic u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (prep_valid),
        .in_ready  (prep_ready),
        .in_item   (prep_item),
        .out_valid (cor_valid),
        .out_ready (cor_ready),
        .out_item  (cor_item)
    );

    // radius scaling and output register
    llsx_scale u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (cor_valid),
        .in_ready  (cor_ready),
        .in_item   (cor_item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .x_coord   (x_coord),
        .y_coord   (y_coord),
        .z_coord   (z_coord)
    );

    assign m_tdata = {2'b00, z_coord, y_coord, x_coord};

endmodule

`default_nettype wire

[src/llsx_core_checker.sv]
// llsx_core_checker: port-level assertions for lonlat_to_sphere_xyz_core
// attached by the bind at the end of this file; no package dependencies
`timescale 1ns / 1ps
`default_nettype none

module llsx_core_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_tready,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [103:0] m_tdata,
    input wire logic         pready
);

    // a reset always leaves the output empty
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("m_tvalid set after reset");

    // an empty or draining output stage frees the whole ready chain
    a_ready_chain: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid || m_tready) |-> s_tready)
        else $error("s_tready low while output stage can move");

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

    // pad bits of the result stay zero and the config port never waits
    a_pad_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[103:102] == 2'b00 && pready))
        else $error("result padding or pready wrong");

endmodule

bind lonlat_to_sphere_xyz_core llsx_core_checker u_llsx_core_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .pready   (pready)
);

`default_nettype wire
